[rtl/core/jsuv_pkg.sv]
// Shared types and constants of the JSON string unescape and validate unit.
package jsuv_pkg;

    localparam int OFFSET_BITS = 32;
    localparam int LIMIT_BITS  = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 16'd4096;

    typedef enum logic [3:0] {
        MODE_IDLE    = 4'd0,
        MODE_STR     = 4'd1,
        MODE_ESC     = 4'd2,
        MODE_HEX1    = 4'd3,
        MODE_WANT_BS = 4'd4,
        MODE_WANT_U  = 4'd5,
        MODE_HEX2    = 4'd6,
        MODE_UTF8    = 4'd7
    } mode_t;

    typedef enum logic [2:0] {
        DIAG_NONE           = 3'd0,
        DIAG_INVALID_JSON   = 3'd1,
        DIAG_INVALID_ESCAPE = 3'd2,
        DIAG_INVALID_UNICODE = 3'd3,
        DIAG_LIMIT_EXCEEDED = 3'd4
    } diag_t;

    // One queued job: either 1..4 decoded bytes or one status result.
    typedef struct packed {
        logic                   is_status;
        logic [2:0]             nbytes;
        logic [3:0][7:0]        bytes;
        logic                   valid_res;
        logic                   limited;
        diag_t                  code;
        logic [OFFSET_BITS-1:0] doff;
        logic [OFFSET_BITS-1:0] endp;
    } job_t;

endpackage

[rtl/core/jsuv_front.sv]
// Front end: parses each byte, tracks limit, and emits at most one job per item.
module jsuv_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_fire,
    input  logic                            operation,
    input  logic [7:0]                      data_byte,
    input  logic [jsuv_pkg::OFFSET_BITS-1:0] byte_offset,
    input  logic [jsuv_pkg::OFFSET_BITS-1:0] string_start,
    input  logic                            cfg_fire,
    input  logic [jsuv_pkg::LIMIT_BITS-1:0] cfg_data,
    output logic                            push,
    output jsuv_pkg::job_t                  job
);
    import jsuv_pkg::*;

    mode_t mode_reg, mode_next;
    logic [2:0]  hex_left_reg, hex_left_next;
    logic [20:0] acc_reg, acc_next;
    logic [9:0]  hs_reg, hs_next;
    logic [23:0] pend_reg, pend_next;
    logic [1:0]  cont_reg, cont_next;
    logic [OFFSET_BITS-1:0] esc_off_reg, esc_off_next;
    logic [OFFSET_BITS-1:0] start_reg, start_next;
    logic [LIMIT_BITS-1:0]  cnt_reg, cnt_next;
    logic                   lim_hit_reg, lim_hit_next;
    logic [OFFSET_BITS-1:0] lim_off_reg, lim_off_next;
    logic [LIMIT_BITS-1:0]  max_reg;

    logic [2:0]      rk, kept;
    logic [3:0][7:0] rb;
    logic            stat;
    logic            st_valid;
    diag_t           st_code;
    logic [OFFSET_BITS-1:0] st_doff, st_endp, boff;
    logic [LIMIT_BITS:0]    avail;
    logic [15:0] hex_acc;
    logic [20:0] cp, u8_acc;
    logic [31:0] all;
    logic [20:0] minimum;
    logic [4:0]  hv;
    logic [1:0]  cl;

    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) r = {1'b1, 4'(b - 8'h30)};
        else if (b >= 8'h61 && b <= 8'h66) r = {1'b1, 4'(b - 8'h57)};
        else if (b >= 8'h41 && b <= 8'h46) r = {1'b1, 4'(b - 8'h37)};
        return r;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_IDLE;
            hex_left_reg <= '0;
            acc_reg     <= '0;
            hs_reg      <= '0;
            pend_reg    <= '0;
            cont_reg    <= '0;
            esc_off_reg <= '0;
            start_reg   <= '0;
            cnt_reg     <= '0;
            lim_hit_reg <= 1'b0;
            lim_off_reg <= '0;
            max_reg     <= LIMIT_RESET;
        end else begin
            mode_reg    <= mode_next;
            hex_left_reg <= hex_left_next;
            acc_reg     <= acc_next;
            hs_reg      <= hs_next;
            pend_reg    <= pend_next;
            cont_reg    <= cont_next;
            esc_off_reg <= esc_off_next;
            start_reg   <= start_next;
            cnt_reg     <= cnt_next;
            lim_hit_reg <= lim_hit_next;
            lim_off_reg <= lim_off_next;
            if (cfg_fire) begin
                max_reg <= cfg_data;
            end
        end
    end

    always_comb begin
        mode_next     = mode_reg;
        hex_left_next = hex_left_reg;
        acc_next      = acc_reg;
        hs_next       = hs_reg;
        pend_next     = pend_reg;
        cont_next     = cont_reg;
        esc_off_next  = esc_off_reg;
        start_next    = start_reg;
        cnt_next      = cnt_reg;
        lim_hit_next  = lim_hit_reg;
        lim_off_next  = lim_off_reg;
        rk       = 3'd0;
        rb       = '0;
        stat     = 1'b0;
        st_valid = 1'b0;
        st_code  = DIAG_NONE;
        st_doff  = '0;
        st_endp  = '0;
        boff     = esc_off_reg;
        hex_acc  = {acc_reg[11:0], 4'd0};
        cp       = '0;
        u8_acc   = '0;
        all      = '0;
        minimum  = '0;
        hv       = hex_value(data_byte);
        cl       = cont_reg - 2'd1;

        if (in_fire) begin
            unique case (mode_reg)
                MODE_STR: begin
                    if (operation) begin
                        stat = 1'b1; st_code = DIAG_INVALID_JSON; st_doff = start_reg;
                    end else if (data_byte == 8'h22) begin
                        stat = 1'b1; st_valid = 1'b1;
                        st_code = lim_hit_reg ? DIAG_LIMIT_EXCEEDED : DIAG_NONE;
                        st_doff = lim_hit_reg ? lim_off_reg : '0;
                        st_endp = byte_offset + 1'b1;
                    end else if (data_byte == 8'h5C) begin
                        esc_off_next = byte_offset;
                        mode_next = MODE_ESC;
                    end else if (data_byte < 8'h20) begin
                        stat = 1'b1; st_code = DIAG_INVALID_JSON; st_doff = byte_offset;
                    end else if (data_byte < 8'h80) begin
                        rk = 3'd1; rb[0] = data_byte; boff = byte_offset;
                    end else if (data_byte >= 8'hC2 && data_byte <= 8'hF4) begin
                        esc_off_next = byte_offset;
                        pend_next = {16'd0, data_byte};
                        if (data_byte <= 8'hDF) begin
                            acc_next = {16'd0, data_byte[4:0]}; cont_next = 2'd1;
                        end else if (data_byte <= 8'hEF) begin
                            acc_next = {17'd0, data_byte[3:0]}; cont_next = 2'd2;
                        end else begin
                            acc_next = {18'd0, data_byte[2:0]}; cont_next = 2'd3;
                        end
                        mode_next = MODE_UTF8;
                    end else begin
                        stat = 1'b1; st_code = DIAG_INVALID_UNICODE; st_doff = byte_offset;
                    end
                end
                MODE_ESC: begin
                    mode_next = MODE_STR;
                    if (operation) begin
                        stat = 1'b1; st_code = DIAG_INVALID_ESCAPE; st_doff = esc_off_reg;
                    end else begin
                        case (data_byte)
                            8'h22, 8'h5C, 8'h2F: begin rk = 3'd1; rb[0] = data_byte; end
                            8'h62: begin rk = 3'd1; rb[0] = 8'h08; end
                            8'h66: begin rk = 3'd1; rb[0] = 8'h0C; end
                            8'h6E: begin rk = 3'd1; rb[0] = 8'h0A; end
                            8'h72: begin rk = 3'd1; rb[0] = 8'h0D; end
                            8'h74: begin rk = 3'd1; rb[0] = 8'h09; end
                            8'h75: begin
                                acc_next = '0; hex_left_next = 3'd4; mode_next = MODE_HEX1;
                            end
                            default: begin
                                stat = 1'b1; st_code = DIAG_INVALID_ESCAPE;
                                st_doff = esc_off_reg;
                            end
                        endcase
                    end
                end
                MODE_HEX1, MODE_HEX2: begin
                    if (operation || !hv[4]) begin
                        stat = 1'b1; st_code = DIAG_INVALID_UNICODE; st_doff = esc_off_reg;
                    end else begin
                        hex_acc = {acc_reg[11:0], hv[3:0]};
                        acc_next = {5'd0, hex_acc};
                        hex_left_next = hex_left_reg - 3'd1;
                        if (hex_left_next == 3'd0) begin
                            if (mode_reg == MODE_HEX1) begin
                                if (hex_acc >= 16'hDC00) begin
                                    if (hex_acc <= 16'hDFFF) begin
                                        stat = 1'b1; st_code = DIAG_INVALID_UNICODE;
                                        st_doff = esc_off_reg;
                                    end else begin
                                        cp = {5'd0, hex_acc}; mode_next = MODE_STR;
                                    end
                                end else if (hex_acc >= 16'hD800) begin
                                    hs_next = hex_acc[9:0]; mode_next = MODE_WANT_BS;
                                end else begin
                                    cp = {5'd0, hex_acc}; mode_next = MODE_STR;
                                end
                            end else begin
                                if (hex_acc < 16'hDC00 || hex_acc > 16'hDFFF) begin
                                    stat = 1'b1; st_code = DIAG_INVALID_UNICODE;
                                    st_doff = esc_off_reg;
                                end else begin
                                    cp = 21'h10000 + {1'b0, hs_reg, hex_acc[9:0]};
                                    mode_next = MODE_STR;
                                end
                            end
                            if (!stat && mode_next == MODE_STR) begin
                                if (cp <= 21'h7F) begin
                                    rk = 3'd1; rb[0] = cp[7:0];
                                end else if (cp <= 21'h7FF) begin
                                    rk = 3'd2;
                                    rb[0] = {3'b110, cp[10:6]};
                                    rb[1] = {2'b10, cp[5:0]};
                                end else if (cp <= 21'hFFFF) begin
                                    rk = 3'd3;
                                    rb[0] = {4'b1110, cp[15:12]};
                                    rb[1] = {2'b10, cp[11:6]};
                                    rb[2] = {2'b10, cp[5:0]};
                                end else begin
                                    rk = 3'd4;
                                    rb[0] = {5'b11110, cp[20:18]};
                                    rb[1] = {2'b10, cp[17:12]};
                                    rb[2] = {2'b10, cp[11:6]};
                                    rb[3] = {2'b10, cp[5:0]};
                                end
                            end
                        end
                    end
                end
                MODE_WANT_BS: begin
                    if (operation || data_byte != 8'h5C) begin
                        stat = 1'b1; st_code = DIAG_INVALID_UNICODE; st_doff = esc_off_reg;
                    end else begin
                        mode_next = MODE_WANT_U;
                    end
                end
                MODE_WANT_U: begin
                    if (operation || data_byte != 8'h75) begin
                        stat = 1'b1; st_code = DIAG_INVALID_UNICODE; st_doff = esc_off_reg;
                    end else begin
                        acc_next = '0; hex_left_next = 3'd4; mode_next = MODE_HEX2;
                    end
                end
                MODE_UTF8: begin
                    if (operation || data_byte[7:6] != 2'b10) begin
                        stat = 1'b1; st_code = DIAG_INVALID_UNICODE; st_doff = esc_off_reg;
                    end else begin
                        u8_acc = {acc_reg[14:0], data_byte[5:0]};
                        acc_next = u8_acc;
                        cont_next = cl;
                        if (cl != 2'd0) begin
                            pend_next = {pend_reg[15:0], data_byte};
                        end else begin
                            all = {pend_reg, data_byte};
                            if (pend_reg[23:16] != 8'd0) minimum = 21'h10000;
                            else if (pend_reg[15:8] != 8'd0) minimum = 21'h800;
                            else minimum = 21'h80;
                            if (u8_acc < minimum || u8_acc > 21'h10FFFF ||
                                (u8_acc >= 21'hD800 && u8_acc <= 21'hDFFF)) begin
                                stat = 1'b1; st_code = DIAG_INVALID_UNICODE;
                                st_doff = esc_off_reg;
                            end else begin
                                // lead byte goes to lane 0, played out first
                                if (pend_reg[23:16] != 8'd0) begin
                                    rk = 3'd4;
                                    rb = {all[7:0], all[15:8], all[23:16], all[31:24]};
                                end else if (pend_reg[15:8] != 8'd0) begin
                                    rk = 3'd3;
                                    rb = {8'd0, all[7:0], all[15:8], all[23:16]};
                                end else begin
                                    rk = 3'd2;
                                    rb = {16'd0, all[7:0], all[15:8]};
                                end
                                pend_next = '0;
                                mode_next = MODE_STR;
                            end
                        end
                    end
                end
                default: begin
                    start_next = string_start;
                    cnt_next = '0; lim_hit_next = 1'b0; lim_off_next = '0;
                    hex_left_next = '0; cont_next = '0; acc_next = '0;
                    hs_next = '0; pend_next = '0;
                    if (!operation && data_byte == 8'h22) begin
                        mode_next = MODE_STR;
                    end else begin
                        stat = 1'b1; st_code = DIAG_INVALID_JSON; st_doff = byte_offset;
                    end
                end
            endcase
            if (stat) begin
                mode_next = MODE_IDLE;
            end
        end

        // bytes past the limit are dropped; the first drop records its offset
        avail = (cnt_reg >= max_reg) ? '0 : ({1'b0, max_reg} - {1'b0, cnt_reg});
        kept  = ({14'd0, rk} < avail) ? rk : avail[2:0];
        if (rk != 3'd0) begin
            cnt_next = cnt_reg + {13'd0, kept};
            if (kept != rk && !lim_hit_reg) begin
                lim_hit_next = 1'b1;
                lim_off_next = boff;
            end
        end
    end

    assign push = stat || (kept != 3'd0);

    always_comb begin
        job.is_status = stat;
        job.nbytes    = kept;
        job.bytes     = rb;
        job.valid_res = st_valid;
        job.limited   = lim_hit_next;
        job.code      = st_code;
        job.doff      = st_doff;
        job.endp      = st_endp;
    end

endmodule

[rtl/core/jsuv_queue.sv]
// Short job queue between the parsing front end and the output back end.
module jsuv_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  jsuv_pkg::job_t push_job,
    input  logic           pop,
    output logic           not_empty,
    output logic           not_full,
    output jsuv_pkg::job_t head
);
    import jsuv_pkg::*;

    job_t entries_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_reg, rd_reg;
    logic [QUEUE_AW:0]   count_reg;

    assign not_empty = (count_reg != '0);
    assign not_full  = (count_reg != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign head      = entries_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end else begin
            if (push) wr_reg <= wr_reg + 1'b1;
            if (pop)  rd_reg <= rd_reg + 1'b1;
            count_reg <= count_reg + {{QUEUE_AW{1'b0}}, push} - {{QUEUE_AW{1'b0}}, pop};
        end
    end

endmodule

[rtl/core/jsuv_back.sv]
// Back end: plays each job out as result transfers, one a cycle while m_ready is high.
module jsuv_back (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             q_not_empty,
    input  jsuv_pkg::job_t                   q_head,
    output logic                             q_pop,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_out_kind,
    output logic [7:0]                       m_out_byte,
    output logic                             m_valid_res,
    output logic                             m_limited,
    output logic [2:0]                       m_diag_code,
    output logic [jsuv_pkg::OFFSET_BITS-1:0] m_diag_offset,
    output logic [jsuv_pkg::OFFSET_BITS-1:0] m_end_position,
    output logic                             m_last
);
    import jsuv_pkg::*;

    job_t       job_reg;
    logic       busy_reg;
    logic [1:0] idx_reg;
    logic       is_last;

    assign is_last = job_reg.is_status || ({1'b0, idx_reg} == job_reg.nbytes - 3'd1);
    assign q_pop   = q_not_empty && (!busy_reg || (m_ready && is_last));

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            job_reg <= q_head;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else if (q_pop) begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end else if (busy_reg && m_ready) begin
            if (is_last) busy_reg <= 1'b0;
            idx_reg <= idx_reg + 2'd1;
        end
    end

    assign m_valid        = busy_reg;
    assign m_out_kind     = job_reg.is_status;
    assign m_out_byte     = job_reg.is_status ? 8'd0 : job_reg.bytes[idx_reg];
    assign m_valid_res    = job_reg.is_status && job_reg.valid_res;
    assign m_limited      = job_reg.is_status && job_reg.limited;
    assign m_diag_code    = job_reg.is_status ? job_reg.code : DIAG_NONE;
    assign m_diag_offset  = job_reg.is_status ? job_reg.doff : '0;
    assign m_end_position = job_reg.is_status ? job_reg.endp : '0;
    assign m_last         = is_last;

endmodule

[rtl/core/json_string_unescape_validate_unit.sv]
// Each item's job passes through a queue entry and the back end's job register before its first result.
// Throughput: one input byte per cycle while the queue is not full; an item giving k results makes k output transfers.
// A four-entry job queue between parser and output lets either side stall alone.
// Reset (aresetn low, synchronous) returns to awaiting an opening quote with the
// limit register at 4096 and the queue empty.
module json_string_unescape_validate_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_operation,
    input  logic [7:0]                       s_data_byte,
    input  logic [jsuv_pkg::OFFSET_BITS-1:0] s_byte_offset,
    input  logic [jsuv_pkg::OFFSET_BITS-1:0] s_string_start,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [jsuv_pkg::LIMIT_BITS-1:0]  cfg_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_out_kind,
    output logic [7:0]                       m_out_byte,
    output logic                             m_valid_res,
    output logic                             m_limited,
    output logic [2:0]                       m_diag_code,
    output logic [jsuv_pkg::OFFSET_BITS-1:0] m_diag_offset,
    output logic [jsuv_pkg::OFFSET_BITS-1:0] m_end_position,
    output logic                             m_last
);
    import jsuv_pkg::*;

    logic push, pop, not_empty, not_full;
    job_t push_job, head;

    assign s_ready   = not_full;
    assign cfg_ready = 1'b1;

    jsuv_front u_front (
        .aclk, .aresetn,
        .in_fire(s_valid && s_ready),
        .operation(s_operation),
        .data_byte(s_data_byte),
        .byte_offset(s_byte_offset),
        .string_start(s_string_start),
        .cfg_fire(cfg_valid && cfg_ready),
        .cfg_data,
        .push,
        .job(push_job)
    );

    jsuv_queue u_queue (
        .aclk, .aresetn,
        .push, .push_job,
        .pop, .not_empty, .not_full, .head
    );

    jsuv_back u_back (
        .aclk, .aresetn,
        .q_not_empty(not_empty), .q_head(head), .q_pop(pop),
        .m_valid, .m_ready, .m_out_kind, .m_out_byte, .m_valid_res, .m_limited,
        .m_diag_code, .m_diag_offset, .m_end_position, .m_last
    );

endmodule

[rtl/core/jsuv_checker.sv]
// Port-level checker for the unescape unit, bound to the top level.
module jsuv_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_out_kind,
    input logic [7:0] m_out_byte,
    input logic       m_valid_res,
    input logic       m_limited,
    input logic [2:0] m_diag_code,
    input logic       m_last
);
    import jsuv_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_out_kind))
        else $error("stalled result changed");

    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_out_kind |-> m_last)
        else $error("status transfer not last");

    a_byte_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_out_kind |-> !m_valid_res && !m_limited && m_diag_code == DIAG_NONE)
        else $error("byte transfer carries status");

    a_ok_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_valid_res |-> (m_diag_code == DIAG_NONE ||
                                    m_diag_code == DIAG_LIMIT_EXCEEDED))
        else $error("valid string with error code");

endmodule

bind json_string_unescape_validate_unit jsuv_checker u_jsuv_checker (
    .aclk, .aresetn, .m_valid, .m_ready, .m_out_kind, .m_out_byte,
    .m_valid_res, .m_limited, .m_diag_code, .m_last
);
